### rtl/pcrr_pkg.sv
// shared types, constants and page geometry of the printer raster renderer
`default_nettype none
package pcrr_pkg;

    localparam int CHARS_PER_LINE = 80;
    localparam int LINES_PER_PAGE = 64;
    localparam int PAGE_MARGIN    = 8;

    localparam int DOT_WIDTH     = (2 * PAGE_MARGIN + CHARS_PER_LINE * 8 + 7) / 8 * 8;
    localparam int BYTES_PER_ROW = (DOT_WIDTH / 8 + 3) / 4 * 4;
    localparam int TEXT_RIGHT    = PAGE_MARGIN + CHARS_PER_LINE * 8;
    localparam int TEXT_BOTTOM   = PAGE_MARGIN + LINES_PER_PAGE * 8;

    localparam logic [15:0] MARGIN_W = 16'(PAGE_MARGIN);
    localparam logic [15:0] BPR_W    = 16'(BYTES_PER_ROW);
    localparam logic [16:0] RIGHT_W  = 17'(TEXT_RIGHT);
    localparam logic [16:0] BOTTOM_W = 17'(TEXT_BOTTOM);

    localparam int FONT_DEPTH = 2048;
    localparam int FONT_AW    = 11;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] GAP_RESET = 4'd2;

    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CMD_GAP_DEF = 8'h02;
    localparam logic [7:0] CMD_GAP_ZERO = 8'h41;
    localparam logic [7:0] CMD_GFX     = 8'h4b;
    localparam logic [7:0] CMD_SKIP    = 8'h4e;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_FEED = 2'd1,
        OP_FONT = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic {
        CFG_DEFAULT_ROW_GAP = 1'b0,
        CFG_AUTO_FEED       = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        JOB_FONT  = 2'd0,
        JOB_CHAR  = 2'd1,
        JOB_GFX   = 2'd2,
        JOB_EJECT = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic              eject;
        logic [15:0]       addr;
        logic [7:0]        value;
        logic [7:0]        mask;
        logic [FONT_AW-1:0] font_addr;
    } job_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] addr;
        logic [7:0]  mask;
        logic        is_char;
        logic        last;
    } beat_t;

endpackage
`default_nettype wire

### rtl/pcrr_in_if.sv
// input channel: printer bytes, feed requests and font loads
`default_nettype none
interface pcrr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  byte_value;
    logic [10:0] font_address;
    logic        manual_feed;

    modport source (output valid, operation, byte_value, font_address, manual_feed,
                    input ready);
    modport sink (input valid, operation, byte_value, font_address, manual_feed,
                  output ready);
endinterface
`default_nettype wire

### rtl/pcrr_out_if.sv
// output channel: page store writes and page ejects
`default_nettype none
interface pcrr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [7:0]  write_mask;
    logic        last;

    modport source (output valid, kind, write_address, write_data, write_mask, last,
                    input ready);
    modport sink (input valid, kind, write_address, write_data, write_mask, last,
                  output ready);
endinterface
`default_nettype wire

### rtl/printer_command_raster_renderer_unit.sv
// the first beat of an accepted byte passes through the job fifo, the s1 beat register and the output register
// throughput: one beat per cycle while dout.ready does not stall the output; a character or graphics byte is
// 8 beats, 9 with an eject; the single output register is fed from the font memory read port
// a new item is taken each cycle while the 4-entry job fifo has room
// reset: cursor at the margin, escape parser idle, gap 2; font memory is not cleared
`default_nettype none
module printer_command_raster_renderer_unit import pcrr_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    pcrr_in_if.sink         din,
    pcrr_out_if.source      dout,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [3:0] cfg_data
);
    logic push, full, pop, head_valid;
    job_t push_job, head;

    pcrr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (full),
        .push      (push),
        .job       (push_job)
    );

    pcrr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    pcrr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head),
        .pop       (pop),
        .dout      (dout)
    );
endmodule
`default_nettype wire

### rtl/pcrr_ram.sv
// generic single write port ram with registered read
`default_nettype none
module pcrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

### rtl/pcrr_front.sv
// front end: escape parsing, cursor tracking and job classification
`default_nettype none
module pcrr_front import pcrr_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pcrr_in_if.sink          din,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data,
    input  wire logic        q_full,
    output logic             push,
    output job_t             job
);
    logic [3:0]  dgap_reg;
    logic        auto_reg;
    logic [15:0] cx_reg, cx_next;
    logic [15:0] cy_reg, cy_next;
    logic [3:0]  gap_reg, gap_next;
    logic        esc_reg, esc_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [1:0]  pl_reg, pl_next;
    logic [7:0]  low_reg, low_next;
    logic        gact_reg, gact_next;
    logic [15:0] rem_reg, rem_next;

    logic        accept;
    logic [31:0] prod;
    logic [15:0] base;
    logic [7:0]  v;
    logic        want;
    logic        ej;

    assign din.ready = !q_full;
    assign accept    = din.valid && din.ready;
    assign v         = din.byte_value;

    assign prod = cy_reg * BPR_W;
    assign base = prod[15:0] + {3'b000, cx_reg[15:3]};

    always_comb
    begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        gap_next  = gap_reg;
        esc_next  = esc_reg;
        cmd_next  = cmd_reg;
        pl_next   = pl_reg;
        low_next  = low_reg;
        gact_next = gact_reg;
        rem_next  = rem_reg;
        want      = 1'b0;
        ej        = 1'b0;
        job.kind      = JOB_FONT;
        job.eject     = 1'b0;
        job.addr      = base;
        job.value     = v;
        job.mask      = 8'h80 >> cx_reg[2:0];
        job.font_addr = din.font_address;

        case (op_t'(din.operation))
            OP_BYTE:
            begin
                if (pl_reg != 2'd0)
                begin
                    pl_next = pl_reg - 2'd1;
                    if (cmd_reg == CMD_GFX)
                    begin
                        if (pl_next == 2'd1)
                        begin
                            low_next = v;
                        end
                        else
                        begin
                            rem_next  = {v, low_reg};
                            gact_next = rem_next != 16'd0;
                            cx_next   = (cx_reg + 16'd7) & ~16'd7;
                        end
                    end
                    if (pl_next == 2'd0)
                    begin
                        esc_next = 1'b0;
                    end
                end
                else if (v == CH_ESC)
                begin
                    esc_next = 1'b1;
                end
                else if (esc_reg)
                begin
                    case (v)
                        CMD_GAP_DEF:
                        begin
                            gap_next = dgap_reg;
                            esc_next = 1'b0;
                        end
                        CMD_GAP_ZERO:
                        begin
                            gap_next = 4'd0;
                            cmd_next = v;
                            pl_next  = 2'd1;
                        end
                        CMD_GFX:
                        begin
                            cmd_next = v;
                            pl_next  = 2'd2;
                        end
                        CMD_SKIP:
                        begin
                            cmd_next = v;
                            pl_next  = 2'd1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (gact_reg)
                begin
                    want     = 1'b1;
                    job.kind = JOB_GFX;
                    cx_next  = cx_reg + 16'd1;
                    rem_next = rem_reg - 16'd1;
                    if (rem_next == 16'd0)
                    begin
                        gact_next = 1'b0;
                        cx_next   = (cx_next + 16'd7) & ~16'd7;
                    end
                    if ({1'b0, cx_next} >= RIGHT_W)
                    begin
                        cx_next = MARGIN_W;
                        cy_next = cy_reg + 16'd8 + {12'd0, gap_reg};
                    end
                    ej = 1'b1;
                end
                else if (v == CH_LF)
                begin
                    if (cx_reg != MARGIN_W)
                    begin
                        cx_next = MARGIN_W;
                        cy_next = cy_reg + 16'd8 + {12'd0, gap_reg};
                        ej      = 1'b1;
                    end
                end
                else if ((v >= 8'h20 && v <= 8'h7e) || (v >= 8'ha1 && v <= 8'hdf))
                begin
                    want     = 1'b1;
                    job.kind = JOB_CHAR;
                    cx_next  = cx_reg + 16'd8;
                    if ({1'b0, cx_next} >= RIGHT_W)
                    begin
                        cx_next = MARGIN_W;
                        cy_next = cy_reg + 16'd8 + {12'd0, gap_reg};
                    end
                    ej = 1'b1;
                end
                // bottom of text area reached: eject and home
                if (ej && ({1'b0, cy_next} + 17'd8 >= BOTTOM_W))
                begin
                    job.eject = 1'b1;
                    cx_next   = MARGIN_W;
                    cy_next   = MARGIN_W;
                    if (!want)
                    begin
                        want     = 1'b1;
                        job.kind = JOB_EJECT;
                    end
                end
            end
            OP_FEED:
            begin
                if ((auto_reg || din.manual_feed) && (cx_reg != MARGIN_W || cy_reg != MARGIN_W))
                begin
                    want     = 1'b1;
                    job.kind = JOB_EJECT;
                    cx_next  = MARGIN_W;
                    cy_next  = MARGIN_W;
                end
            end
            OP_FONT:
            begin
                want     = 1'b1;
                job.kind = JOB_FONT;
            end
            default:
            begin
            end
        endcase
    end

    assign push = accept && want;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dgap_reg <= GAP_RESET;
            auto_reg <= 1'b0;
            cx_reg   <= MARGIN_W;
            cy_reg   <= MARGIN_W;
            gap_reg  <= GAP_RESET;
            esc_reg  <= 1'b0;
            cmd_reg  <= 8'd0;
            pl_reg   <= 2'd0;
            low_reg  <= 8'd0;
            gact_reg <= 1'b0;
            rem_reg  <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_DEFAULT_ROW_GAP: dgap_reg <= cfg_data;
                    CFG_AUTO_FEED:       auto_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                cx_reg   <= cx_next;
                cy_reg   <= cy_next;
                gap_reg  <= gap_next;
                esc_reg  <= esc_next;
                cmd_reg  <= cmd_next;
                pl_reg   <= pl_next;
                low_reg  <= low_next;
                gact_reg <= gact_next;
                rem_reg  <= rem_next;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/pcrr_queue.sv
// small job fifo between front end and drawing back end
`default_nettype none
module pcrr_queue import pcrr_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head
);
    localparam int AW = $clog2(QUEUE_DEPTH);

    job_t          slots [QUEUE_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg, cnt_next;

    assign full       = cnt_reg == (AW + 1)'(QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head       = slots[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wp_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/pcrr_back.sv
// back end: font memory, row sequencing and the output register
`default_nettype none
module pcrr_back import pcrr_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    input  job_t      job,
    output logic      pop,
    pcrr_out_if.source dout
);
    logic [3:0]  step_reg, step_next;
    logic [15:0] row_reg, row_next;
    logic        s1_valid_reg;
    beat_t       s1_reg;
    beat_t       beat;
    logic        issue;
    logic        adv1, can_issue;
    logic        ram_we, ram_re;
    logic [7:0]  rdata;
    logic [15:0] addr;

    logic        s2_valid_reg;
    logic        s2_kind_reg;
    logic [15:0] s2_addr_reg;
    logic [7:0]  s2_data_reg;
    logic [7:0]  s2_mask_reg;
    logic        s2_last_reg;

    assign adv1      = s1_valid_reg && (!s2_valid_reg || dout.ready);
    assign can_issue = !s1_valid_reg || adv1;
    assign addr      = (step_reg == 4'd0) ? job.addr : row_reg;

    always_comb
    begin
        issue     = 1'b0;
        pop       = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        step_next = step_reg;
        row_next  = row_reg;
        beat      = '0;
        if (job_valid && can_issue)
        begin
            case (job.kind)
                JOB_FONT:
                begin
                    ram_we = 1'b1;
                    pop    = 1'b1;
                end
                JOB_EJECT:
                begin
                    issue     = 1'b1;
                    pop       = 1'b1;
                    beat.kind = 1'b1;
                    beat.last = 1'b1;
                end
                JOB_CHAR, JOB_GFX:
                begin
                    issue = 1'b1;
                    if (step_reg[3])
                    begin
                        // trailing eject after the eight dot rows
                        beat.kind = 1'b1;
                        beat.last = 1'b1;
                        pop       = 1'b1;
                        step_next = 4'd0;
                    end
                    else
                    begin
                        beat.addr    = addr;
                        beat.is_char = job.kind == JOB_CHAR;
                        beat.mask    = beat.is_char ? 8'hff :
                                       (job.value[3'd7 - step_reg[2:0]] ? job.mask : 8'h00);
                        beat.last    = step_reg == 4'd7 && !job.eject;
                        ram_re       = beat.is_char;
                        row_next     = addr + BPR_W;
                        if (step_reg == 4'd7)
                        begin
                            pop       = !job.eject;
                            step_next = job.eject ? 4'd8 : 4'd0;
                        end
                        else
                        begin
                            step_next = step_reg + 4'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    pcrr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .clk   (clk),
        .we    (ram_we),
        .waddr (job.font_addr),
        .wdata (job.value),
        .re    (ram_re),
        .raddr ({job.value, step_reg[2:0]}),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_reg <= beat;
        end
        if (adv1)
        begin
            s2_kind_reg <= s1_reg.kind;
            s2_addr_reg <= s1_reg.addr;
            s2_data_reg <= s1_reg.is_char ? ~rdata : 8'h00;
            s2_mask_reg <= s1_reg.mask;
            s2_last_reg <= s1_reg.last;
        end
        if (issue || (step_reg == 4'd0 && job_valid && can_issue))
        begin
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= 4'd0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (can_issue)
            begin
                s1_valid_reg <= issue;
            end
            if (adv1)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    assign dout.valid         = s2_valid_reg;
    assign dout.kind          = s2_kind_reg;
    assign dout.write_address = s2_addr_reg;
    assign dout.write_data    = s2_data_reg;
    assign dout.write_mask    = s2_mask_reg;
    assign dout.last          = s2_last_reg;
endmodule
`default_nettype wire
